// File: rtl/psop_pkg.sv
// ----------------------------------------------------------------------------
// psop_pkg
// Shared constants, the control word carried between the front and back
// parts, and the arctangent table of the vectoring rotator.
// ----------------------------------------------------------------------------
package psop_pkg;

	localparam int MAX_OSC_DEF  = 16;
	localparam int WINDOW_DEF   = 14;
	localparam int UNIT_Q16     = 65536;
	localparam int HALF_PI_Q16  = 102944;
	localparam int PI_Q13       = 25736;
	localparam int CORDIC_STEPS = 17;
	localparam int DIV_QBITS    = 26;
	localparam int ROOT_STEPS   = 31;

	// control word that travels with each queued transaction
	typedef struct packed {
		logic       clear;
		logic       has_phasor;
		logic       step_end;
		logic       two_results;
		logic [4:0] cnt;
	} item_ctrl_t;

	localparam int CTRL_W = $bits(item_ctrl_t);

	// atan(2^-i) in Q16 radians
	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0:    v = 16'd51472;
			5'd1:    v = 16'd30386;
			5'd2:    v = 16'd16055;
			5'd3:    v = 16'd8150;
			5'd4:    v = 16'd4091;
			5'd5:    v = 16'd2047;
			5'd6:    v = 16'd1024;
			5'd7:    v = 16'd512;
			5'd8:    v = 16'd256;
			5'd9:    v = 16'd128;
			5'd10:   v = 16'd64;
			5'd11:   v = 16'd32;
			5'd12:   v = 16'd16;
			5'd13:   v = 16'd8;
			5'd14:   v = 16'd4;
			5'd15:   v = 16'd2;
			5'd16:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/phase_sync_order_parameter_top.sv
// Path: the front stage, then the queue, then the back stage per sample with a phasor
// (normalise, 31-step root, two 26-step divides), plus a close of step (root, divide,
// 17 CORDIC steps) before the result is queued.
// Pace: set by the back stage once phasors are formed; each stage takes a new sample
// only when done with the last. Samples of the first step of a series carry no phasor.
// Reset: asynchronous, active low; clears control state, osc_count returns to 1.
// ----------------------------------------------------------------------------
// phase_sync_order_parameter_top
// Streaming phase synchronisation order parameter: front stage for history
// and operands, two-entry queue, back stage for phasor and result arithmetic.
// ----------------------------------------------------------------------------
module phase_sync_order_parameter_top import psop_pkg::*; #(
	parameter int MAX_OSC = MAX_OSC_DEF,
	parameter int WINDOW  = WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               osc_count_we,
	input  logic [4:0]         osc_count,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] sample,
	input  logic               series_start,
	output logic               empty,
	input  logic               pop,
	output logic [16:0]        sync_index,
	output logic signed [15:0] mean_angle,
	output logic               is_last
);

	localparam int NW  = $clog2(WINDOW + 2);
	localparam int OPW = 33 + NW;
	localparam int QW  = 2 * OPW + CTRL_W;

	logic [4:0]    osc_count_q;
	logic          q_push;
	logic [QW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic [QW-1:0] q_rdata;
	logic          q_empty;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_count_q <= 5'd1;
		end else if (osc_count_we) begin
			osc_count_q <= osc_count;
		end
	end

	psop_front #(
		.MAX_OSC (MAX_OSC),
		.WINDOW  (WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.osc_count    (osc_count_q),
		.push         (push),
		.sample       (sample),
		.series_start (series_start),
		.full         (full),
		.q_push       (q_push),
		.q_data       (q_wdata),
		.q_full       (q_full)
	);

	psop_queue #(
		.DW (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_push  (q_push),
		.wr_data  (q_wdata),
		.wr_full  (q_full),
		.rd_pop   (q_pop),
		.rd_data  (q_rdata),
		.rd_empty (q_empty)
	);

	psop_back #(
		.MAX_OSC (MAX_OSC),
		.WINDOW  (WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_pop        (q_pop),
		.q_data       (q_rdata),
		.q_empty      (q_empty),
		.empty        (empty),
		.pop          (pop),
		.sync_index   (sync_index),
		.mean_angle   (mean_angle),
		.is_last      (is_last)
	);

endmodule

// File: rtl/psop_queue.sv
// ----------------------------------------------------------------------------
// psop_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module psop_queue import psop_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_push,
	input  logic [DW-1:0] wr_data,
	output logic          wr_full,
	input  logic          rd_pop,
	output logic [DW-1:0] rd_data,
	output logic          rd_empty
);

	logic [DW-1:0] data_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_full  = (cnt_q == 2'd2);
	assign rd_empty = (cnt_q == 2'd0);
	assign rd_data  = data_q[rp_q];
	assign do_wr    = wr_push && !wr_full;
	assign do_rd    = rd_pop && !rd_empty;

	// payload storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

endmodule

// File: rtl/psop_front.sv
// ----------------------------------------------------------------------------
// psop_front
// Takes samples, keeps the per-oscillator history and window sums, forms the
// atan2 operands and the step bookkeeping for each transaction.
// ----------------------------------------------------------------------------
module psop_front import psop_pkg::*; #(
	parameter int MAX_OSC = MAX_OSC_DEF,
	parameter int WINDOW  = WINDOW_DEF,
	localparam int DEPTH  = WINDOW + 1,
	localparam int NW     = $clog2(DEPTH + 1),
	localparam int RW     = $clog2(DEPTH),
	localparam int OW     = (MAX_OSC > 1) ? $clog2(MAX_OSC) : 1,
	localparam int SW     = 32 + NW,
	localparam int OPW    = 33 + NW,
	localparam int ADW    = $clog2(MAX_OSC * DEPTH),
	localparam int QW     = 2 * OPW + CTRL_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         osc_count,
	input  logic               push,
	input  logic signed [31:0] sample,
	input  logic               series_start,
	output logic               full,
	output logic               q_push,
	output logic [QW-1:0]      q_data,
	input  logic               q_full
);

	typedef enum logic [2:0] {F_IDLE, F_RDP, F_RDO, F_CALC, F_PUSH} fstate_t;

	localparam logic [ADW-1:0] DEPTH_A = ADW'(DEPTH);

	fstate_t                  state_q;
	logic signed [31:0]       cur_q;
	logic signed [31:0]       prev_q;
	logic signed [31:0]       rd_q;
	logic                     clr_q;
	logic [4:0]               cnt_q;
	logic [NW-1:0]            fill_q;
	logic [RW-1:0]            rp_q;
	logic [OW-1:0]            idx_q;
	logic                     first_q;
	logic signed [SW-1:0]     wsum_q [MAX_OSC];
	logic signed [31:0]       hist_mem [MAX_OSC * DEPTH];
	logic signed [OPW-1:0]    x_q;
	logic signed [OPW-1:0]    y_q;
	item_ctrl_t               ctrl_q;

	logic [4:0]               cnt_eff;
	logic [RW-1:0]            rp_prev;
	logic [ADW-1:0]           base_a;
	logic [ADW-1:0]           rd_addr;
	logic [ADW-1:0]           wr_addr;
	logic                     mem_we;
	logic                     full_win;
	logic [NW-1:0]            n_w;
	logic signed [SW-1:0]     wold;
	logic signed [SW-1:0]     wnew;
	logic signed [OPW-1:0]    n_s;
	logic signed [OPW-1:0]    diff;
	logic                     step_end;

	// count register clamped to the supported range
	always_comb begin
		if (osc_count == 5'd0) begin
			cnt_eff = 5'd1;
		end else if (int'(osc_count) > MAX_OSC) begin
			cnt_eff = 5'(MAX_OSC);
		end else begin
			cnt_eff = osc_count;
		end
	end

	// history addressing
	assign rp_prev = (rp_q == '0) ? RW'(DEPTH - 1) : rp_q - 1'b1;
	assign base_a  = ADW'(idx_q) * DEPTH_A;
	assign rd_addr = (state_q == F_RDP) ? base_a + ADW'(rp_prev) : base_a + ADW'(rp_q);
	assign wr_addr = base_a + ADW'(rp_q);
	assign mem_we  = (state_q == F_CALC);

	// window sum update and atan2 operands
	assign full_win = (fill_q >= NW'(DEPTH));
	assign n_w      = full_win ? NW'(DEPTH) : fill_q + 1'b1;
	assign wold     = wsum_q[idx_q];
	assign wnew     = wold - (full_win ? SW'(rd_q) : SW'(0)) + SW'(cur_q);
	assign n_s      = OPW'({1'b0, n_w});
	assign diff     = OPW'(cur_q) - OPW'(prev_q);
	assign step_end = (int'(idx_q) + 1 >= int'(cnt_q));

	assign full   = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = {x_q, y_q, ctrl_q};

	// sample history memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[wr_addr] <= cur_q;
		end
		rd_q <= hist_mem[rd_addr];
	end

	// sequencer and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q  <= '0;
			rp_q    <= '0;
			idx_q   <= '0;
			first_q <= 1'b1;
			clr_q   <= 1'b0;
			cnt_q   <= 5'd1;
			for (int k = 0; k < MAX_OSC; k++) begin
				wsum_q[k] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						cur_q   <= sample;
						clr_q   <= series_start;
						cnt_q   <= cnt_eff;
						state_q <= F_RDP;
						if (series_start) begin
							fill_q  <= '0;
							rp_q    <= '0;
							idx_q   <= '0;
							first_q <= 1'b1;
							for (int k = 0; k < MAX_OSC; k++) begin
								wsum_q[k] <= '0;
							end
						end
					end
				end
				F_RDP: begin
					state_q <= F_RDO;
				end
				F_RDO: begin
					prev_q  <= rd_q;
					state_q <= F_CALC;
				end
				F_CALC: begin
					wsum_q[idx_q]      <= wnew;
					x_q                <= n_s * OPW'(cur_q) - OPW'(wnew);
					y_q                <= n_s * diff;
					ctrl_q.clear       <= clr_q;
					ctrl_q.has_phasor  <= (fill_q != '0);
					ctrl_q.step_end    <= step_end;
					ctrl_q.two_results <= first_q;
					ctrl_q.cnt         <= cnt_q;
					if (step_end) begin
						idx_q <= '0;
						rp_q  <= (int'(rp_q) + 1 >= DEPTH) ? '0 : rp_q + 1'b1;
						if (!full_win) begin
							fill_q <= fill_q + 1'b1;
						end
						if (fill_q != '0) begin
							first_q <= 1'b0;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/psop_back.sv
// ----------------------------------------------------------------------------
// psop_back
// Unit phasor per transaction (square root and divide), phasor sums, and at
// step end the magnitude and CORDIC angle, written to a two-entry result queue.
// ----------------------------------------------------------------------------
module psop_back import psop_pkg::*; #(
	parameter int MAX_OSC = MAX_OSC_DEF,
	parameter int WINDOW  = WINDOW_DEF,
	localparam int NW     = $clog2(WINDOW + 2),
	localparam int OPW    = 33 + NW,
	localparam int QW     = 2 * OPW + CTRL_W,
	localparam int SUMW   = 18 + $clog2(MAX_OSC),
	localparam int CW     = SUMW + 11
) (
	input  logic               clk,
	input  logic               arst_n,
	output logic               q_pop,
	input  logic [QW-1:0]      q_data,
	input  logic               q_empty,
	output logic               empty,
	input  logic               pop,
	output logic [16:0]        sync_index,
	output logic signed [15:0] mean_angle,
	output logic               is_last
);

	typedef enum logic [3:0] {
		B_IDLE, B_NORM, B_SQX, B_SQY, B_SQRT, B_SQD, B_DIV, B_DVD,
		B_ACC, B_END, B_CORD, B_ANG, B_OUT
	} bstate_t;

	typedef enum logic [1:0] {D_COS, D_SIN, D_MAG} dsel_t;

	bstate_t               state_q;
	dsel_t                 dsel_q;
	item_ctrl_t            ctrl_q;
	logic [OPW-1:0]        ax_q;
	logic [OPW-1:0]        ay_q;
	logic                  sx_q;
	logic                  sy_q;
	logic signed [SUMW-1:0] sr_q;
	logic signed [SUMW-1:0] si_q;
	logic [16:0]           cm_q;
	logic [16:0]           sm_q;
	logic                  mag_mode_q;
	logic [61:0]           v_q;
	logic [61:0]           r_q;
	logic [61:0]           b_q;
	logic [4:0]            sq_cnt_q;
	logic [30:0]           rem_q;
	logic [25:0]           nlo_q;
	logic [25:0]           quo_q;
	logic [30:0]           den_q;
	logic [4:0]            dcnt_q;
	logic [16:0]           mag_q;
	logic signed [CW-1:0]  cx_q;
	logic signed [CW-1:0]  cy_q;
	logic signed [19:0]    cz_q;
	logic [4:0]            ci_q;
	logic signed [15:0]    ang_q;

	// result queue
	logic [16:0]           om_q [2];
	logic signed [15:0]    oa_q [2];
	logic                  ol_q [2];
	logic                  owp_q;
	logic                  orp_q;
	logic [1:0]            ocnt_q;

	// unpacked queue entry
	logic signed [OPW-1:0] in_x;
	logic signed [OPW-1:0] in_y;
	item_ctrl_t            in_ctrl;

	logic [OPW-1:0]        in_ax;
	logic [OPW-1:0]        in_ay;
	logic [SUMW-1:0]       abs_r;
	logic [SUMW-1:0]       abs_i;
	logic [29:0]           mul_a;
	logic [59:0]           mul_p;
	logic [61:0]           rt_t;
	logic [31:0]           trial;
	logic                  ge;
	logic [30:0]           rr_ph;
	logic [30:0]           rr_mag;
	logic [47:0]           num_c;
	logic [47:0]           num_s;
	logic [47:0]           num_m;
	logic signed [CW-1:0]  xe;
	logic signed [CW-1:0]  ye;
	logic signed [CW-1:0]  xs;
	logic signed [CW-1:0]  ys;
	logic signed [19:0]    at_z;
	logic signed [19:0]    zr;
	logic signed [SUMW-1:0] c_add;
	logic signed [SUMW-1:0] s_add;
	logic                  out_room;
	logic                  do_opop;
	logic                  wr_one;
	logic                  wr_two;

	assign {in_x, in_y, in_ctrl} = q_data;
	assign in_ax = in_x[OPW-1] ? OPW'(-in_x) : OPW'(in_x);
	assign in_ay = in_y[OPW-1] ? OPW'(-in_y) : OPW'(in_y);
	assign abs_r = sr_q[SUMW-1] ? SUMW'(-sr_q) : SUMW'(sr_q);
	assign abs_i = si_q[SUMW-1] ? SUMW'(-si_q) : SUMW'(si_q);

	assign q_pop = (state_q == B_IDLE) && !q_empty;

	// shared squarer
	always_comb begin
		if (state_q == B_SQX) begin
			mul_a = mag_mode_q ? 30'(abs_r) : ax_q[29:0];
		end else begin
			mul_a = mag_mode_q ? 30'(abs_i) : ay_q[29:0];
		end
	end
	assign mul_p = mul_a * mul_a;

	// square root step
	assign rt_t = r_q + b_q;

	// divider step
	assign trial = {rem_q, nlo_q[25]};
	assign ge    = (trial >= {1'b0, den_q});

	// divider operands
	assign rr_ph  = (r_q[30:0] == '0) ? 31'd1 : r_q[30:0];
	assign rr_mag = r_q[30:0] + 31'(v_q > r_q);
	assign num_c  = (48'(ax_q[29:0]) << 16) + 48'(rr_ph >> 1);
	assign num_s  = (48'(ay_q[29:0]) << 16) + 48'(den_q >> 1);
	assign num_m  = 48'(rr_mag) + 48'(ctrl_q.cnt >> 1);

	// cordic operands
	assign xe   = CW'(sr_q) <<< 8;
	assign ye   = CW'(si_q) <<< 8;
	assign xs   = cx_q >>> ci_q;
	assign ys   = cy_q >>> ci_q;
	assign at_z = 20'(atan_q16(ci_q));
	assign zr   = (cz_q + 20'sd4) >>> 3;

	assign c_add = sx_q ? -SUMW'(cm_q) : SUMW'(cm_q);
	assign s_add = sy_q ? -SUMW'(sm_q) : SUMW'(sm_q);

	// result queue handshake
	assign empty        = (ocnt_q == 2'd0);
	assign sync_index   = om_q[orp_q];
	assign mean_angle   = oa_q[orp_q];
	assign is_last      = ol_q[orp_q];
	assign do_opop      = pop && !empty;
	assign out_room     = ctrl_q.two_results ? (ocnt_q == 2'd0) : (ocnt_q != 2'd2);
	assign wr_one       = (state_q == B_OUT) && out_room && !ctrl_q.two_results;
	assign wr_two       = (state_q == B_OUT) && out_room && ctrl_q.two_results;

	// result payload storage
	always_ff @(posedge clk) begin
		if (wr_one) begin
			om_q[owp_q] <= mag_q;
			oa_q[owp_q] <= ang_q;
			ol_q[owp_q] <= 1'b1;
		end
		if (wr_two) begin
			om_q[owp_q]  <= mag_q;
			oa_q[owp_q]  <= ang_q;
			ol_q[owp_q]  <= 1'b0;
			om_q[~owp_q] <= mag_q;
			oa_q[~owp_q] <= ang_q;
			ol_q[~owp_q] <= 1'b1;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			dsel_q     <= D_COS;
			sr_q       <= '0;
			si_q       <= '0;
			mag_mode_q <= 1'b0;
			owp_q      <= 1'b0;
			orp_q      <= 1'b0;
			ocnt_q     <= 2'd0;
		end else begin
			if (do_opop) begin
				orp_q <= ~orp_q;
			end
			if (wr_one) begin
				owp_q <= ~owp_q;
			end
			ocnt_q <= ocnt_q + (wr_two ? 2'd2 : {1'b0, wr_one}) - {1'b0, do_opop};

			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						ctrl_q     <= in_ctrl;
						ax_q       <= in_ax;
						ay_q       <= in_ay;
						sx_q       <= in_x[OPW-1];
						sy_q       <= in_y[OPW-1];
						mag_mode_q <= 1'b0;
						if (in_ctrl.clear) begin
							sr_q <= '0;
							si_q <= '0;
						end
						if (!in_ctrl.has_phasor) begin
							state_q <= B_END;
						end else if (in_x == '0 && in_y == '0) begin
							// atan2(0,0) gives the phasor (1, 0)
							cm_q    <= 17'(UNIT_Q16);
							sm_q    <= '0;
							state_q <= B_ACC;
						end else begin
							state_q <= B_NORM;
						end
					end
				end
				// bring both operands below 2^30
				B_NORM: begin
					if (|((ax_q | ay_q) >> 30)) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
					end else begin
						state_q <= B_SQX;
					end
				end
				B_SQX: begin
					v_q     <= 62'(mul_p);
					state_q <= B_SQY;
				end
				B_SQY: begin
					v_q      <= v_q + 62'(mul_p);
					r_q      <= '0;
					b_q      <= 62'd1 << 60;
					sq_cnt_q <= '0;
					state_q  <= B_SQRT;
				end
				// one result bit per cycle, remainder left in v
				B_SQRT: begin
					if (v_q >= rt_t) begin
						v_q <= v_q - rt_t;
						r_q <= (r_q >> 1) + b_q;
					end else begin
						r_q <= r_q >> 1;
					end
					b_q      <= b_q >> 2;
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (int'(sq_cnt_q) == ROOT_STEPS - 1) begin
						state_q <= B_SQD;
					end
				end
				B_SQD: begin
					dcnt_q <= '0;
					if (mag_mode_q) begin
						rem_q  <= 31'(num_m[47:DIV_QBITS]);
						nlo_q  <= num_m[DIV_QBITS-1:0];
						den_q  <= 31'(ctrl_q.cnt);
						dsel_q <= D_MAG;
					end else begin
						rem_q  <= 31'(num_c[47:DIV_QBITS]);
						nlo_q  <= num_c[DIV_QBITS-1:0];
						den_q  <= rr_ph;
						dsel_q <= D_COS;
					end
					state_q <= B_DIV;
				end
				// restoring division, one quotient bit per cycle
				B_DIV: begin
					rem_q  <= ge ? 31'(trial - {1'b0, den_q}) : 31'(trial);
					nlo_q  <= nlo_q << 1;
					quo_q  <= {quo_q[24:0], ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (int'(dcnt_q) == DIV_QBITS - 1) begin
						state_q <= B_DVD;
					end
				end
				B_DVD: begin
					case (dsel_q)
						D_COS: begin
							cm_q    <= quo_q[16:0];
							rem_q   <= 31'(num_s[47:DIV_QBITS]);
							nlo_q   <= num_s[DIV_QBITS-1:0];
							dcnt_q  <= '0;
							dsel_q  <= D_SIN;
							state_q <= B_DIV;
						end
						D_SIN: begin
							sm_q    <= quo_q[16:0];
							state_q <= B_ACC;
						end
						default: begin
							mag_q <= (quo_q > 26'(UNIT_Q16)) ? 17'(UNIT_Q16) : quo_q[16:0];
							ci_q  <= '0;
							// quadrant pre-rotation
							if (xe < 0) begin
								if (ye >= 0) begin
									cx_q <= ye;
									cy_q <= -xe;
									cz_q <= 20'(HALF_PI_Q16);
								end else begin
									cx_q <= -ye;
									cy_q <= xe;
									cz_q <= -20'(HALF_PI_Q16);
								end
							end else begin
								cx_q <= xe;
								cy_q <= ye;
								cz_q <= '0;
							end
							state_q <= B_CORD;
						end
					endcase
				end
				B_ACC: begin
					sr_q    <= sr_q + c_add;
					si_q    <= si_q + s_add;
					state_q <= B_END;
				end
				B_END: begin
					if (ctrl_q.step_end && ctrl_q.has_phasor) begin
						mag_mode_q <= 1'b1;
						state_q    <= B_SQX;
					end else begin
						if (ctrl_q.step_end) begin
							sr_q <= '0;
							si_q <= '0;
						end
						state_q <= B_IDLE;
					end
				end
				// vectoring rotations
				B_CORD: begin
					if (cy_q > 0) begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + at_z;
					end else begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - at_z;
					end
					ci_q <= ci_q + 1'b1;
					if (int'(ci_q) == CORDIC_STEPS - 1) begin
						state_q <= B_ANG;
					end
				end
				B_ANG: begin
					if (sr_q == '0 && si_q == '0) begin
						ang_q <= '0;
					end else if (zr > 20'(PI_Q13)) begin
						ang_q <= 16'(PI_Q13);
					end else if (zr < -20'(PI_Q13)) begin
						ang_q <= -16'(PI_Q13);
					end else begin
						ang_q <= 16'(zr);
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_room) begin
						sr_q    <= '0;
						si_q    <= '0;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/psop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psop_checker
// Watches the sample, result and count channels of the order parameter
// block, keeps its own copy of the history and phasor arithmetic, and
// compares every result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module psop_checker import psop_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               osc_count_we,
	input  logic [4:0]         osc_count,
	input  logic               push,
	input  logic               full,
	input  logic signed [31:0] sample,
	input  logic               series_start,
	input  logic               empty,
	input  logic               pop,
	input  logic [16:0]        sync_index,
	input  logic signed [15:0] mean_angle,
	input  logic               is_last,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);

	localparam int DEPTH = WINDOW_DEF + 1;
	localparam longint ATAN_TAB [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	typedef struct packed {
		logic [16:0]        mag;
		logic signed [15:0] ang;
		logic               last;
	} order_result_t;

	order_result_t order_q[$];

	longint     hist [MAX_OSC_DEF][DEPTH];
	longint     wsum [MAX_OSC_DEF];
	int         fill;
	int         rptr;
	int         oidx;
	longint     sum_re;
	longint     sum_im;
	bit         zero_owed;
	logic [4:0] count_reg;

	// integer square root, floor
	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit phasor of (x, y) in Q16
	task automatic unit_vec(input longint x, input longint y, output longint c,
		output longint s);
		longint unsigned ax, ay, r, cm, sm;
		if (x == 0 && y == 0) begin
			c = UNIT_Q16;
			s = 0;
			return;
		end
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		while ((ax | ay) >= (64'd1 << 30)) begin
			ax >>= 1;
			ay >>= 1;
		end
		r = isqrt(ax * ax + ay * ay);
		if (r == 0)
			r = 1;
		cm = (ax * UNIT_Q16 + r / 2) / r;
		sm = (ay * UNIT_Q16 + r / 2) / r;
		c = (x < 0) ? -longint'(cm) : longint'(cm);
		s = (y < 0) ? -longint'(sm) : longint'(sm);
	endtask

	// vectoring angle of the phasor sum, Q3.13
	function automatic longint sum_angle(input longint re, input longint im);
		longint x, y, z, t, a, xs, ys;
		if (re == 0 && im == 0)
			return 0;
		x = re * 256;
		y = im * 256;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q16;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z += ATAN_TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z -= ATAN_TAB[i];
			end
		end
		a = (z + 4) >>> 3;
		if (a > PI_Q13)
			a = PI_Q13;
		if (a < -PI_Q13)
			a = -PI_Q13;
		return a;
	endfunction

	task automatic clear_series();
		fill = 0;
		rptr = 0;
		oidx = 0;
		sum_re = 0;
		sum_im = 0;
		zero_owed = 1;
		for (int k = 0; k < MAX_OSC_DEF; k++)
			wsum[k] = 0;
	endtask

	// fold one sample into the history and queue the results it closes
	task automatic predict_order(input logic signed [31:0] smp, input logic start);
		longint cur, prev, c, s, n, sq, r, mag, ang;
		int cnt, i, rp;
		order_result_t res;
		if (start)
			clear_series();
		cnt = (count_reg == 0) ? 1 : (count_reg > MAX_OSC_DEF) ? MAX_OSC_DEF : count_reg;
		cur = longint'(smp);
		i = oidx % MAX_OSC_DEF;
		rp = rptr % DEPTH;
		prev = 0;
		if (fill >= 1)
			prev = hist[i][(rp + DEPTH - 1) % DEPTH];
		if (fill >= DEPTH)
			wsum[i] -= hist[i][rp];
		hist[i][rp] = cur;
		wsum[i] += cur;
		if (fill >= 1) begin
			n = (fill + 1 > DEPTH) ? DEPTH : fill + 1;
			unit_vec(n * cur - wsum[i], n * (cur - prev), c, s);
			sum_re += c;
			sum_im += s;
		end
		if (oidx + 1 < cnt) begin
			oidx++;
			return;
		end
		// step closes
		if (fill >= 1) begin
			sq = sum_re * sum_re + sum_im * sum_im;
			r = isqrt(sq);
			if (sq - r * r > r)
				r++;
			mag = (r + cnt / 2) / cnt;
			if (mag > UNIT_Q16)
				mag = UNIT_Q16;
			ang = sum_angle(sum_re, sum_im);
			res.mag = mag[16:0];
			res.ang = ang[15:0];
			if (zero_owed) begin
				res.last = 1'b0;
				order_q.push_back(res);
			end
			res.last = 1'b1;
			order_q.push_back(res);
			zero_owed = 0;
		end
		sum_re = 0;
		sum_im = 0;
		oidx = 0;
		rptr = (rp + 1 >= DEPTH) ? 0 : rp + 1;
		if (fill < DEPTH)
			fill++;
	endtask

	// channel monitor and comparison
	always @(posedge clk or negedge arst_n) begin
		order_result_t exp_r;
		if (!arst_n) begin
			order_q.delete();
			for (int a = 0; a < MAX_OSC_DEF; a++)
				for (int b = 0; b < DEPTH; b++)
					hist[a][b] = 0;
			clear_series();
			count_reg = 1;
			fail_count = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			// a sample accepted on a count write edge still sees the old count
			if (push && !full)
				predict_order(sample, series_start);
			if (osc_count_we)
				count_reg = osc_count;
			if (pop && !empty) begin
				results_seen++;
				if (order_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result transaction mag=%0d phase=%0d last=%0b",
						$time, sync_index, mean_angle, is_last);
				end else begin
					exp_r = order_q.pop_front();
					if (sync_index !== exp_r.mag) begin
						fail_count++;
						$display("%0t: sync_index expected %0d actual %0d",
							$time, exp_r.mag, sync_index);
					end
					if (mean_angle !== exp_r.ang) begin
						fail_count++;
						$display("%0t: mean_angle expected %0d actual %0d",
							$time, exp_r.ang, mean_angle);
					end
					if (is_last !== exp_r.last) begin
						fail_count++;
						$display("%0t: is_last expected %0b actual %0b",
							$time, exp_r.last, is_last);
					end
				end
			end
			pending = order_q.size();
		end
	end

endmodule

// File: tb/tb_phase_sync_order_parameter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_sync_order_parameter_top
// Drives sample transactions and oscillator count settings into the order
// parameter block under several idle patterns and one long result hold-off;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_phase_sync_order_parameter_top import psop_pkg::*; ();

	localparam int SETTLE_CYCLES = 800;
	localparam int HOLD_CYCLES   = 3000;
	localparam int HOLD_PHASE    = 2;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               osc_count_we = 1'b0;
	logic [4:0]         osc_count    = 5'd1;
	logic               push         = 1'b0;
	logic signed [31:0] sample       = '0;
	logic               series_start = 1'b0;
	logic               pop          = 1'b0;
	logic               full;
	logic               empty;
	logic [16:0]        sync_index;
	logic signed [15:0] mean_angle;
	logic               is_last;

	int fail_count;
	int pending;
	int results_seen;

	int tx_pct;
	int rx_pct;
	int phase_no;
	int samples_sent;
	int settings_used;
	int cur_count;
	int trend [MAX_OSC_DEF];

	phase_sync_order_parameter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.osc_count_we (osc_count_we),
		.osc_count    (osc_count),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.series_start (series_start),
		.empty        (empty),
		.pop          (pop),
		.sync_index   (sync_index),
		.mean_angle   (mean_angle),
		.is_last      (is_last)
	);

	psop_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.osc_count_we (osc_count_we),
		.osc_count    (osc_count),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.series_start (series_start),
		.empty        (empty),
		.pop          (pop),
		.sync_index   (sync_index),
		.mean_angle   (mean_angle),
		.is_last      (is_last),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always #5 clk = ~clk;

	// watchdog
	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && phase_no == HOLD_PHASE) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) < rx_pct) ? 1'b0 : 1'b1;
			end
		end
	end

	function automatic int eff_count(input int v);
		return (v == 0) ? 1 : (v > MAX_OSC_DEF) ? MAX_OSC_DEF : v;
	endfunction

	// one sample transaction, push kept high across back-to-back items
	task automatic send_sample(input logic signed [31:0] s, input logic st);
		if ($urandom_range(99) < tx_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		series_start <= st;
		@(posedge clk);
		while (full)
			@(posedge clk);
		samples_sent++;
	endtask

	// count write once the block has drained
	task automatic write_count(input int v);
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		osc_count_we <= 1'b1;
		osc_count <= v[4:0];
		@(posedge clk);
		osc_count_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic signed [31:0] pick_sample(input int o);
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) begin
			trend[o] += $urandom_range(0, 4000) - 2000;
			return trend[o];
		end else if (roll < 60) begin
			return $urandom;
		end else if (roll < 70) begin
			return trend[o];
		end else if (roll < 80) begin
			case ($urandom_range(4))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		return $urandom_range(0, 512) - 256;
	endfunction

	// one phase of random series at a given count and idle pattern
	task automatic run_phase(input int v, input int mode, input int n_items);
		int cnt, left, steps, o;
		bit st;
		write_count(v);
		case (mode)
			0: begin tx_pct = 0;  rx_pct = 0;  end
			1: begin tx_pct = 49; rx_pct = 0;  end
			2: begin tx_pct = 0;  rx_pct = 49; end
			default: begin tx_pct = 20; rx_pct = 20; end
		endcase
		phase_no++;
		cnt = eff_count(v);
		// a raised count needs a fresh series, a lowered one may run on
		st = (cnt > cur_count) || $urandom_range(1);
		cur_count = cnt;
		left = n_items;
		while (left > 0) begin
			steps = $urandom_range(2, 20);
			for (int k = 0; k < steps * cnt && left > 0; k++) begin
				o = k % cnt;
				if ($urandom_range(99) < 4)
					st = 1;
				send_sample(pick_sample(o), st);
				st = 0;
				left--;
			end
			st = 1;
		end
	endtask

	initial begin
		int counts [12] = '{1, 3, 16, 0, 31, 2, 7, 1, 16, 4, 9, 1};
		logic signed [31:0] edge_vals [8] = '{32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, -32'sd1, 32'sd1};
		tx_pct = 0;
		rx_pct = 0;
		phase_no = 0;
		samples_sent = 0;
		settings_used = 0;
		cur_count = 1;
		for (int k = 0; k < MAX_OSC_DEF; k++)
			trend[k] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single oscillator: extreme samples, constant run gives atan2(0,0)
		for (int k = 0; k < 8; k++)
			send_sample(edge_vals[k], k == 0);

		// two oscillators with opposite phasors: zero sum on the third step
		write_count(2);
		send_sample(32'sd5, 1'b1);
		send_sample(32'sd10, 1'b0);
		send_sample(32'sd5, 1'b0);
		send_sample(32'sd0, 1'b0);
		send_sample(32'sd5, 1'b0);
		send_sample(32'sd0, 1'b0);

		// count lowered part way through a step: early close, saturation
		write_count(5);
		for (int k = 0; k < 8; k++)
			send_sample(32'sd1000 * (k % 5) * (k / 5 + 1), k == 0);
		write_count(2);
		for (int k = 0; k < 3; k++)
			send_sample(32'sd777 * k, 1'b0);
		cur_count = 2;

		// random phases
		for (int p = 0; p < 12; p++)
			run_phase(counts[p], p % 4, 115);
		push <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d samples and %0d results over %0d count settings,",
			samples_sent, results_seen, settings_used);
		$display("with sender gaps, result stalls and a long result hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
